FILE: hw/rtl/cst_pkg.sv
package cst_pkg;

  localparam int POSITION_BITS = 16;
  typedef logic [POSITION_BITS-1:0] pos_t;
  localparam pos_t POS_MAX = '1;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_source;
  } src_t;

  typedef struct packed {
    logic [4:0]  token_kind;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [7:0]  token_length;
    logic        last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0] count;
    tok_t       first;
    tok_t       second;
  } push_t;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_NUM,
    MODE_IDENT,
    MODE_DONE
  } mode_t;

  localparam logic [4:0] KIND_INT_LIT    = 5'd0;
  localparam logic [4:0] KIND_IDENT      = 5'd1;
  localparam logic [4:0] KIND_KW_BASE    = 5'd2;
  localparam logic [4:0] KIND_PUNCT_BASE = 5'd7;
  localparam logic [4:0] KIND_END        = 5'd17;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_NEWLINE    = 8'h0A;
  localparam logic [7:0] CH_UNDERSCORE = "_";

  localparam int KW_COUNT = 5;
  localparam int KW_MAX_LEN = 6;
  localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd3, 8'd6, 8'd2, 8'd4, 8'd5};
  localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n"},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00}
  };

  localparam int PUNCT_COUNT = 10;
  localparam logic [7:0] PUNCT_CHARS [PUNCT_COUNT] =
    '{"+", "-", "*", "/", "=", "(", ")", "{", "}", ";"};

  typedef struct packed {
    logic       hit;
    logic [4:0] kind;
  } punct_t;

  function automatic logic is_digit(logic [7:0] b);
    return b inside {["0":"9"]};
  endfunction

  function automatic logic is_alpha(logic [7:0] b);
    return b inside {["a":"z"], ["A":"Z"]};
  endfunction

  function automatic logic is_word_start(logic [7:0] b);
    return is_alpha(b) || (b == CH_UNDERSCORE);
  endfunction

  function automatic logic is_word_char(logic [7:0] b);
    return is_alpha(b) || is_digit(b) || (b == CH_UNDERSCORE);
  endfunction

  function automatic pos_t sat_inc(pos_t v);
    return (v == POS_MAX) ? v : v + pos_t'(1);
  endfunction

  function automatic logic [15:0] sat_out(pos_t v);
    logic [32:0] w;
    w = 33'(v);
    return (w > 33'h0FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  // Drop every keyword that cannot match once byte b sits at position run_len.
  function automatic logic [KW_COUNT-1:0] kw_update(logic [KW_COUNT-1:0] cand,
                                                   logic [7:0] run_len,
                                                   logic [7:0] b);
    logic [KW_COUNT-1:0] res;
    res = cand;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (run_len >= KW_LEN[k]) begin
        res[k] = 1'b0;
      end else if (KW_TEXT[k][run_len[2:0]] != b) begin
        res[k] = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic logic [4:0] word_kind(logic [KW_COUNT-1:0] cand, logic [7:0] run_len);
    logic [4:0] kind;
    kind = KIND_IDENT;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      if (cand[k] && (run_len == KW_LEN[k])) begin
        kind = KIND_KW_BASE + 5'(k);
      end
    end
    return kind;
  endfunction

  function automatic punct_t punct_lookup(logic [7:0] b);
    punct_t p;
    p = '0;
    for (int k = 0; k < PUNCT_COUNT; k++) begin
      if (b == PUNCT_CHARS[k]) begin
        p.hit  = 1'b1;
        p.kind = KIND_PUNCT_BASE + 5'(k);
      end
    end
    return p;
  endfunction

  function automatic tok_t make_tok(logic [4:0] kind, pos_t line, pos_t col,
                                    logic [7:0] len);
    tok_t t;
    t.token_kind   = kind;
    t.token_line   = sat_out(line);
    t.token_column = sat_out(col);
    t.token_length = len;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

endpackage

FILE: hw/rtl/cst_step.sv
module cst_step (
  input  logic          clk,
  input  logic          rst,
  input  logic          fire,
  input  cst_pkg::src_t item,
  output cst_pkg::push_t push
);
  import cst_pkg::*;

  mode_t               mode, mode_next;
  pos_t                line_count, line_count_next;
  pos_t                column_count, column_count_next;
  pos_t                start_column, start_column_next;
  logic [7:0]          run_length, run_length_next;
  logic [KW_COUNT-1:0] keyword_candidates, keyword_candidates_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode               <= MODE_IDLE;
      line_count         <= pos_t'(1);
      column_count       <= pos_t'(1);
      start_column       <= '0;
      run_length         <= '0;
      keyword_candidates <= '1;
    end else begin
      mode               <= mode_next;
      line_count         <= line_count_next;
      column_count       <= column_count_next;
      start_column       <= start_column_next;
      run_length         <= run_length_next;
      keyword_candidates <= keyword_candidates_next;
    end
  end

  logic [7:0] b;
  logic       term;
  logic       cont;
  logic       do_adv;
  logic       pend_valid, new_valid;
  tok_t       pend_tok, new_tok;
  punct_t     punct;
  logic [7:0] run_sat;

  always_comb begin
    b        = item.source_byte;
    term     = item.end_of_source || (b == CH_NUL);
    run_sat  = (run_length == 8'hFF) ? run_length : run_length + 8'd1;
    punct    = punct_lookup(b);

    mode_next               = mode;
    line_count_next         = line_count;
    column_count_next       = column_count;
    start_column_next       = start_column;
    run_length_next         = run_length;
    keyword_candidates_next = keyword_candidates;
    cont       = 1'b0;
    do_adv     = 1'b0;
    pend_valid = 1'b0;
    new_valid  = 1'b0;
    pend_tok   = '0;
    new_tok    = '0;

    if (fire && (mode != MODE_DONE)) begin
      // Extend or close the pending run.
      case (mode)
        MODE_NUM: begin
          if (!term && is_digit(b)) begin
            cont            = 1'b1;
            run_length_next = run_sat;
            do_adv          = 1'b1;
          end else begin
            pend_valid = 1'b1;
            pend_tok   = make_tok(KIND_INT_LIT, line_count, start_column, run_length);
            mode_next  = MODE_IDLE;
          end
        end
        MODE_IDENT: begin
          if (!term && is_word_char(b)) begin
            cont                    = 1'b1;
            keyword_candidates_next = kw_update(keyword_candidates, run_length, b);
            run_length_next         = run_sat;
            do_adv                  = 1'b1;
          end else begin
            pend_valid = 1'b1;
            pend_tok   = make_tok(word_kind(keyword_candidates, run_length),
                                  line_count, start_column, run_length);
            mode_next  = MODE_IDLE;
          end
        end
        default: ;
      endcase

      if (!cont) begin
        if (term) begin
          new_valid = 1'b1;
          new_tok   = make_tok(KIND_END, line_count, column_count, 8'd0);
          mode_next = MODE_DONE;
        end else if (is_digit(b)) begin
          mode_next         = MODE_NUM;
          start_column_next = column_count;
          run_length_next   = 8'd1;
          do_adv            = 1'b1;
        end else if (is_word_start(b)) begin
          mode_next               = MODE_IDENT;
          start_column_next       = column_count;
          keyword_candidates_next = kw_update('1, 8'd0, b);
          run_length_next         = 8'd1;
          do_adv                  = 1'b1;
        end else begin
          if (punct.hit) begin
            new_valid = 1'b1;
            new_tok   = make_tok(punct.kind, line_count, column_count, 8'd1);
          end
          do_adv = 1'b1;
        end
      end
    end

    if (do_adv) begin
      if (b == CH_NEWLINE) begin
        line_count_next   = sat_inc(line_count);
        column_count_next = pos_t'(1);
      end else begin
        column_count_next = sat_inc(column_count);
      end
    end

    push.count              = {1'b0, pend_valid} + {1'b0, new_valid};
    push.first              = pend_valid ? pend_tok : new_tok;
    push.first.last_of_run  = !(pend_valid && new_valid);
    push.second             = new_tok;
    push.second.last_of_run = 1'b1;
  end

endmodule

FILE: hw/rtl/cst_fifo.sv
module cst_fifo (
  input  logic           clk,
  input  logic           rst,
  input  cst_pkg::push_t push,
  input  logic           out_ready,
  output logic           room,
  output logic           out_valid,
  output cst_pkg::tok_t  head
);
  import cst_pkg::*;

  tok_t                     mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CNT_BITS-1:0] count;
  logic                     pop;

  assign out_valid = (count != '0);
  assign pop       = out_valid && out_ready;
  // Keep space for the largest burst one item can cause.
  assign room      = (count <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + FIFO_PTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FIFO_PTR_BITS'(push.count);
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_BITS'(1);
      end
      count <= count + FIFO_CNT_BITS'(push.count) - FIFO_CNT_BITS'(pop);
    end
  end

endmodule

FILE: hw/rtl/c_subset_tokenizer.sv
// A source item is held in the input register, then scanned; any token it makes
// is written into the token queue, raising tok_valid. Throughput: one source
// item per cycle while the queue has room; an item that closes a run and also
// makes a token of its own gives two tokens, both written into the 4-entry
// queue. The input stalls while the queue holds more than two tokens.
// Reset (rst, synchronous): empties the input register and the token queue, sets
// line and column to 1 and the scanner to idle.
module c_subset_tokenizer (
  input  logic          clk,
  input  logic          rst,
  input  logic          src_valid,
  output logic          src_ready,
  input  cst_pkg::src_t src_item,
  output logic          tok_valid,
  input  logic          tok_ready,
  output cst_pkg::tok_t tok_item
);
  import cst_pkg::*;

  logic  src_q_valid;
  src_t  src_q;
  logic  room;
  logic  fire;
  push_t push;

  assign fire      = src_q_valid && room;
  assign src_ready = !src_q_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_q_valid <= 1'b0;
    end else if (src_valid && src_ready) begin
      src_q_valid <= 1'b1;
    end else if (fire) begin
      src_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (src_valid && src_ready) begin
      src_q <= src_item;
    end
  end

  cst_step u_step (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (src_q),
    .push (push)
  );

  cst_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .out_ready (tok_ready),
    .room      (room),
    .out_valid (tok_valid),
    .head      (tok_item)
  );

endmodule

FILE: hw/rtl/cst_checker.sv
module cst_checker (
  input logic          clk,
  input logic          rst,
  input logic          tok_valid,
  input logic          tok_ready,
  input cst_pkg::tok_t tok_item
);
  import cst_pkg::*;

  // Hold a stalled token steady.
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && !tok_ready |=> tok_valid && $stable(tok_item))
    else $error("token changed while stalled");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> tok_item.token_kind <= KIND_END)
    else $error("token kind out of range");

  a_end_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_item.token_kind == KIND_END) |->
      tok_item.last_of_run && (tok_item.token_length == 8'd0))
    else $error("end token malformed");

  a_punct_shape: assert property (@(posedge clk) disable iff (rst)
    tok_valid && (tok_item.token_kind >= KIND_PUNCT_BASE) &&
      (tok_item.token_kind < KIND_END) |->
      tok_item.last_of_run && (tok_item.token_length == 8'd1))
    else $error("punctuator token malformed");

  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_item.token_line != 16'd0) && (tok_item.token_column != 16'd0))
    else $error("token position zero");

endmodule

bind c_subset_tokenizer cst_checker u_cst_checker (
  .clk       (clk),
  .rst       (rst),
  .tok_valid (tok_valid),
  .tok_ready (tok_ready),
  .tok_item  (tok_item)
);
